@@ rtl/core/sat_pkg.sv @@
// Shared types and codes for the sorted address table.
`timescale 1ns / 1ps

package sat_pkg;

	localparam logic [2:0] KIND_INSERT = 3'd0;
	localparam logic [2:0] KIND_LOOKUP = 3'd1;
	localparam logic [2:0] KIND_DELETE = 3'd2;
	localparam logic [2:0] KIND_READ   = 3'd3;
	localparam logic [2:0] KIND_CLEAR  = 3'd4;

	localparam logic [2:0] STAT_INSERTED  = 3'd0;
	localparam logic [2:0] STAT_REPLACED  = 3'd1;
	localparam logic [2:0] STAT_FOUND     = 3'd2;
	localparam logic [2:0] STAT_DELETED   = 3'd3;
	localparam logic [2:0] STAT_NOT_FOUND = 3'd4;
	localparam logic [2:0] STAT_FULL      = 3'd5;
	localparam logic [2:0] STAT_RANGE     = 3'd6;
	localparam logic [2:0] STAT_CLEARED   = 3'd7;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] key_address;
		logic [31:0] name_handle;
		logic [5:0]  position;
	} sat_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] entry_address;
		logic [31:0] entry_handle;
		logic [6:0]  entry_count;
	} sat_rsp_t;

	typedef struct packed {
		logic [31:0] address;
		logic [31:0] handle;
	} sat_entry_t;

endpackage

@@ rtl/core/sorted_address_table_unit.sv @@
// Sorted address table: one entry memory, a binary search and a shift sequencer.
// Lookup runs a probe loop through S_PROBE and S_CMP around the registered read of
// the entry memory. Insert and delete then shift the entries above the slot, one
// at a time; read by index waits for its memory read, and clear and unused kinds
// go straight to the finishing state.
// One word is worked on at a time.
// Reset clears the fill count and the handshake state; the memory is not cleared.
`timescale 1ns / 1ps

module sorted_address_table_unit
	import sat_pkg::*;
#(
	parameter int TABLE_DEPTH = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  sat_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output sat_rsp_t rsp
);

	// Index width into the memory, and count width that can hold the depth itself.
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	// Width used to compare the 6-bit read position against the fill count.
	localparam int PW = (CW > 6) ? CW : 6;

	// Sequencer states.
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_PROBE  = 3'd1;
	localparam logic [2:0] S_CMP    = 3'd2;
	localparam logic [2:0] S_DECIDE = 3'd3;
	localparam logic [2:0] S_SHUP   = 3'd4;
	localparam logic [2:0] S_SHDN   = 3'd5;
	localparam logic [2:0] S_RDWAIT = 3'd6;
	localparam logic [2:0] S_DONE   = 3'd7;

	// The entry memory holds (address, handle) pairs in ascending address order.
	// Only slots below the fill count are ever read in a way that reaches a result.
	sat_entry_t mem [TABLE_DEPTH];
	sat_entry_t rdata_q;
	logic [AW-1:0] mem_ra;
	logic [AW-1:0] mem_wa;
	sat_entry_t    mem_wd;
	logic          mem_we;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rdata_q <= mem[mem_ra];
	end

	logic [2:0]    state_q;
	logic [CW-1:0] fill_q;
	sat_req_t      req_q;
	// Binary search bounds; lo_q ends as the lower bound of the key.
	logic [CW-1:0] lo_q;
	logic [CW-1:0] hi_q;
	logic [CW-1:0] mid_q;
	// Set when the entry at hi_q holds the key, with that entry's handle.
	logic          eq_q;
	logic [31:0]   hnd_q;
	// Shift cursor, plus the write slot of the word read in the previous cycle.
	logic [CW-1:0] cur_q;
	logic          pend_s1;
	logic [AW-1:0] wt_s1;
	// Result being built for the current word.
	logic [2:0]    res_status_q;
	logic [31:0]   res_addr_q;
	logic [31:0]   res_handle_q;
	logic          rsp_valid_q;
	sat_rsp_t      rsp_q;

	logic          accept;
	logic [CW-1:0] mid;
	logic          pos_ok;
	logic          rsp_free;
	logic [CW+6:0] cnt_ext;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign mid       = lo_q + ((hi_q - lo_q) >> 1);
	assign pos_ok    = PW'(req.position) < PW'(fill_q);
	// The output register is free when empty or being emptied this cycle.
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign cnt_ext   = (CW + 7)'(fill_q);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Memory port selection. The read port runs every cycle; only the states
	// below use the data that comes back.
	always_comb begin
		mem_ra = '0;
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = '0;
		case (state_q)
			S_IDLE: begin
				mem_ra = AW'(req.position);
			end
			S_PROBE: begin
				mem_ra = AW'(mid);
			end
			S_DECIDE: begin
				// Insert of an address that is already held overwrites the handle.
				if (req_q.kind == KIND_INSERT && eq_q) begin
					mem_we = 1'b1;
					mem_wa = AW'(lo_q);
					mem_wd = '{address: req_q.key_address, handle: req_q.name_handle};
				end
			end
			S_SHUP: begin
				mem_ra = AW'(cur_q - CW'(1));
				if (pend_s1) begin
					mem_we = 1'b1;
					mem_wa = wt_s1;
					mem_wd = rdata_q;
				end else if (cur_q == lo_q) begin
					// Gap is open at the lower bound: place the new entry.
					mem_we = 1'b1;
					mem_wa = AW'(lo_q);
					mem_wd = '{address: req_q.key_address, handle: req_q.name_handle};
				end
			end
			S_SHDN: begin
				mem_ra = AW'(cur_q);
				if (pend_s1) begin
					mem_we = 1'b1;
					mem_wa = wt_s1;
					mem_wd = rdata_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			pend_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			// A finished word reloads the output register; otherwise a taken word empties it.
			if (state_q == S_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						lo_q         <= '0;
						hi_q         <= fill_q;
						eq_q         <= 1'b0;
						res_addr_q   <= '0;
						res_handle_q <= '0;
						case (req.kind)
							KIND_INSERT, KIND_LOOKUP, KIND_DELETE: begin
								state_q <= S_PROBE;
							end
							KIND_READ: begin
								if (pos_ok) begin
									res_status_q <= STAT_FOUND;
									state_q      <= S_RDWAIT;
								end else begin
									res_status_q <= STAT_RANGE;
									state_q      <= S_DONE;
								end
							end
							KIND_CLEAR: begin
								fill_q       <= '0;
								res_status_q <= STAT_CLEARED;
								state_q      <= S_DONE;
							end
							default: begin
								res_status_q <= STAT_NOT_FOUND;
								state_q      <= S_DONE;
							end
						endcase
					end
				end
				S_PROBE: begin
					mid_q <= mid;
					if (lo_q < hi_q) begin
						state_q <= S_CMP;
					end else begin
						state_q <= S_DECIDE;
					end
				end
				S_CMP: begin
					if (rdata_q.address < req_q.key_address) begin
						lo_q <= mid_q + CW'(1);
					end else begin
						hi_q  <= mid_q;
						eq_q  <= (rdata_q.address == req_q.key_address);
						hnd_q <= rdata_q.handle;
					end
					state_q <= S_PROBE;
				end
				S_DECIDE: begin
					pend_s1 <= 1'b0;
					case (req_q.kind)
						KIND_INSERT: begin
							if (eq_q) begin
								res_status_q <= STAT_REPLACED;
								res_addr_q   <= req_q.key_address;
								res_handle_q <= req_q.name_handle;
								state_q      <= S_DONE;
							end else if (fill_q >= CW'(TABLE_DEPTH)) begin
								res_status_q <= STAT_FULL;
								state_q      <= S_DONE;
							end else begin
								res_status_q <= STAT_INSERTED;
								res_addr_q   <= req_q.key_address;
								res_handle_q <= req_q.name_handle;
								cur_q        <= fill_q;
								state_q      <= S_SHUP;
							end
						end
						KIND_LOOKUP: begin
							if (eq_q) begin
								res_status_q <= STAT_FOUND;
								res_addr_q   <= req_q.key_address;
								res_handle_q <= hnd_q;
							end else begin
								res_status_q <= STAT_NOT_FOUND;
							end
							state_q <= S_DONE;
						end
						default: begin
							if (eq_q) begin
								res_status_q <= STAT_DELETED;
								res_addr_q   <= req_q.key_address;
								res_handle_q <= hnd_q;
								cur_q        <= lo_q + CW'(1);
								state_q      <= S_SHDN;
							end else begin
								res_status_q <= STAT_NOT_FOUND;
								state_q      <= S_DONE;
							end
						end
					endcase
				end
				S_SHUP: begin
					// Move entries up one slot, highest first, one per cycle.
					if (cur_q > lo_q) begin
						pend_s1 <= 1'b1;
						wt_s1   <= AW'(cur_q);
						cur_q   <= cur_q - CW'(1);
					end else begin
						pend_s1 <= 1'b0;
						if (!pend_s1) begin
							fill_q  <= fill_q + CW'(1);
							state_q <= S_DONE;
						end
					end
				end
				S_SHDN: begin
					// Close the gap: move entries down one slot, lowest first.
					if (cur_q < fill_q) begin
						pend_s1 <= 1'b1;
						wt_s1   <= AW'(cur_q - CW'(1));
						cur_q   <= cur_q + CW'(1);
					end else begin
						pend_s1 <= 1'b0;
						if (!pend_s1) begin
							fill_q  <= fill_q - CW'(1);
							state_q <= S_DONE;
						end
					end
				end
				S_RDWAIT: begin
					res_addr_q   <= rdata_q.address;
					res_handle_q <= rdata_q.handle;
					state_q      <= S_DONE;
				end
				S_DONE: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (state_q == S_DONE && rsp_free) begin
			rsp_q <= '{status: res_status_q, entry_address: res_addr_q,
				entry_handle: res_handle_q, entry_count: cnt_ext[6:0]};
		end
	end

	// The table never holds more entries than it has slots.
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(TABLE_DEPTH))
	else $error("fill count exceeds table depth");

	// The memory is written only while deciding or shifting.
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_DECIDE || state_q == S_SHUP || state_q == S_SHDN))
	else $error("memory written outside an update");

	// Shifting up never writes at or below the insertion slot from moved data.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHUP && pend_s1) |-> (CW'(wt_s1) > lo_q))
	else $error("shift up overwrote the insertion slot");

	// A new response word is loaded only from the finishing state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_DONE))
	else $error("response raised outside the finishing state");

endmodule
